[rtl/core/bipt_pkg.sv]
`timescale 1ns / 1ps

package bipt_pkg;

  // Input request types
  typedef enum logic [1:0] {
    REQ_STATE = 2'd0,
    REQ_HEADER = 2'd1,
    REQ_START_QUERY = 2'd2,
    REQ_UNUSED = 2'd3
  } req_type_e;

  // Peer tracking states
  typedef enum logic [1:0] {
    ST_INIT = 2'd0,
    ST_OPEN = 2'd1,
    ST_NORMAL = 2'd2,
    ST_QUERY = 2'd3
  } state_e;

  // Query kind carried by an outgoing header
  typedef enum logic [1:0] {
    Q_NONE = 2'd0,
    Q_NEW = 2'd1,
    Q_REPEAT = 2'd2
  } query_e;

  typedef enum logic [1:0] {
    NOTE_NONE = 2'd0,
    NOTE_REBOOTED = 2'd1,
    NOTE_FIRST = 2'd2
  } notify_e;

  typedef enum logic [1:0] {
    TMR_NONE = 2'd0,
    TMR_START = 2'd1,
    TMR_CANCEL = 2'd2
  } timer_e;

  // Classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_NOP,
    OP_STATE_REQ,
    OP_HEADER,
    OP_START_QUERY
  } op_e;

  // Command queue geometry
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Input word
  typedef struct packed {
    logic [1:0]  req_type;
    logic        flag_bcast;
    logic        flag_query;
    logic        flag_response;
    logic [31:0] src_boot_id;
    logic [31:0] dst_boot_id;
    logic [31:0] in_req_tag;
    logic [31:0] in_rpl_tag;
    logic [31:0] new_tag;
    logic        send_initial;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic        send_valid;
    logic        out_query_flag;
    logic        out_response_flag;
    logic [31:0] out_dst_boot_id;
    logic [31:0] out_req_tag;
    logic [31:0] out_rpl_tag;
    logic [1:0]  notify_code;
    logic        release_waiters;
    logic [1:0]  timer_action;
    logic [1:0]  state_now;
  } out_word_t;

  // Classified command
  typedef struct packed {
    op_e         op;
    logic        bcast;
    logic        query;
    logic        response;
    logic        dst_mismatch;
    logic [31:0] src_boot_id;
    logic [31:0] in_req_tag;
    logic [31:0] in_rpl_tag;
    logic [31:0] new_tag;
    logic        send_initial;
  } cmd_t;

endpackage

[rtl/core/bipt_front.sv]
`timescale 1ns / 1ps

module bipt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [31:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bipt_pkg::in_word_t in_word_i,
  output logic              cmd_valid_o,
  output bipt_pkg::cmd_t    cmd_o,
  input  logic              cmd_full_i
);
  import bipt_pkg::*;

  logic [31:0] my_boot_id_q;
  logic        vld_q, vld_d;
  cmd_t        cmd_q, cmd_d;
  logic        in_acc;

  assign cfg_ready_o = 1'b1;

  // Own boot id register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_boot_id_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      my_boot_id_q <= cfg_data_i;
    end
  end

  // Front register holds while the queue is full
  assign in_stall_o = vld_q && cmd_full_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign vld_d      = in_acc || (vld_q && cmd_full_i);

  // Classify the incoming word
  always_comb begin
    cmd_d = '0;
    unique case (req_type_e'(in_word_i.req_type))
      REQ_STATE:       cmd_d.op = OP_STATE_REQ;
      REQ_HEADER:      cmd_d.op = OP_HEADER;
      REQ_START_QUERY: cmd_d.op = OP_START_QUERY;
      default:         cmd_d.op = OP_NOP;
    endcase
    cmd_d.bcast        = in_word_i.flag_bcast;
    cmd_d.query        = in_word_i.flag_query;
    cmd_d.response     = in_word_i.flag_response;
    cmd_d.dst_mismatch = (in_word_i.dst_boot_id != my_boot_id_q);
    cmd_d.src_boot_id  = in_word_i.src_boot_id;
    cmd_d.in_req_tag   = in_word_i.in_req_tag;
    cmd_d.in_rpl_tag   = in_word_i.in_rpl_tag;
    cmd_d.new_tag      = in_word_i.new_tag;
    cmd_d.send_initial = in_word_i.send_initial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

endmodule

[rtl/core/bipt_cmd_fifo.sv]
`timescale 1ns / 1ps

module bipt_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bipt_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           not_empty_o,
  output bipt_pkg::cmd_t head_o
);
  import bipt_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o      = (cnt_q == QCNT_W'(QDEPTH));
  assign not_empty_o = (cnt_q != '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign head_o      = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/core/bipt_back.sv]
`timescale 1ns / 1ps

module bipt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  bipt_pkg::cmd_t     cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bipt_pkg::out_word_t out_word_o
);
  import bipt_pkg::*;

  state_e      state_q, state_d;
  logic [31:0] peer_id_q, peer_id_d;
  logic [31:0] tag_q, tag_d;
  logic        out_vld_q, out_vld_d;
  out_word_t   out_q, out_d;

  query_e      query;
  logic        send_msg, reply, release_w, send;
  notify_e     note;
  timer_e      tmr;
  logic        src_is_peer, rpl_match;

  // Take the next command whenever the output register frees up
  assign cmd_pop_o = cmd_valid_i && (!out_vld_q || !out_stall_i);
  assign out_vld_d = cmd_pop_o || (out_vld_q && out_stall_i);

  assign src_is_peer = (cmd_i.src_boot_id == peer_id_q);
  assign rpl_match   = cmd_i.response && (cmd_i.in_rpl_tag == tag_q);

  // Per-state rules and outgoing header build
  always_comb begin
    state_d   = state_q;
    peer_id_d = peer_id_q;
    tag_d     = tag_q;
    query     = Q_NONE;
    send_msg  = 1'b0;
    reply     = 1'b0;
    release_w = 1'b0;
    note      = NOTE_NONE;
    tmr       = TMR_NONE;

    unique case (cmd_i.op)
      OP_STATE_REQ: begin
        if (state_q == ST_INIT) begin
          query   = Q_NEW;
          state_d = ST_OPEN;
        end
      end
      OP_START_QUERY: begin
        if (state_q == ST_NORMAL) begin
          state_d = ST_QUERY;
          tmr     = TMR_START;
          if (cmd_i.send_initial) begin
            query = Q_NEW;
          end
        end
      end
      OP_HEADER: begin
        // broadcast from the known peer is dropped whole
        if (!(cmd_i.bcast && src_is_peer)) begin
          unique case (state_q)
            ST_INIT: begin
              query   = Q_NEW;
              state_d = ST_OPEN;
            end
            ST_NORMAL: begin
              if (cmd_i.dst_mismatch && !cmd_i.query) begin
                send_msg = 1'b1;
              end
              if (!src_is_peer) begin
                state_d = ST_QUERY;
                tmr     = TMR_START;
                query   = Q_NEW;
              end
            end
            ST_OPEN: begin
              if (cmd_i.bcast) begin
                query = Q_REPEAT;
              end else if (rpl_match) begin
                peer_id_d = cmd_i.src_boot_id;
                tmr       = TMR_CANCEL;
                release_w = 1'b1;
                note      = NOTE_FIRST;
                state_d   = ST_NORMAL;
              end
            end
            ST_QUERY: begin
              if (cmd_i.bcast) begin
                query = Q_NEW;
              end else if (rpl_match) begin
                tmr = TMR_CANCEL;
                if (!src_is_peer) begin
                  peer_id_d = cmd_i.src_boot_id;
                  note      = NOTE_REBOOTED;
                end
                state_d   = ST_NORMAL;
                release_w = 1'b1;
              end
            end
            default: ;
          endcase
          reply = cmd_i.query;
        end
      end
      default: ;
    endcase

    send = send_msg || (query != Q_NONE) || reply;

    // anything sent while a query is open carries the outstanding tag
    if (send && query == Q_NONE && (state_d == ST_QUERY || state_d == ST_OPEN)) begin
      query = Q_REPEAT;
    end
    if (send && query == Q_NEW) begin
      tag_d = cmd_i.new_tag;
    end

    out_d                   = '0;
    out_d.send_valid        = send;
    out_d.out_query_flag    = send && (query != Q_NONE);
    out_d.out_response_flag = send && reply;
    out_d.out_dst_boot_id   = send ? peer_id_d : '0;
    out_d.out_req_tag       = (send && query != Q_NONE) ? tag_d : '0;
    out_d.out_rpl_tag       = (send && reply) ? cmd_i.in_req_tag : '0;
    out_d.notify_code       = note;
    out_d.release_waiters   = release_w;
    out_d.timer_action      = tmr;
    out_d.state_now         = state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      peer_id_q <= '0;
      tag_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (cmd_pop_o) begin
        state_q   <= state_d;
        peer_id_q <= peer_id_d;
        tag_q     <= tag_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

[rtl/core/boot_id_peer_tracker_fsm.sv]
`timescale 1ns / 1ps

// Boot id peer tracker: follows one peer's boot identifier through the
// INIT, OPEN, NORMAL and QUERY states and gives one result word for every
// input word (optional outgoing header, notify code, release strobe, timer
// strobe, new state). Sustained rate is one word per clock while the output
// is not stalled. An accepted word passes the front classify register, then
// an entry of the two-entry command queue, then the back's output register.
// With the output stalled the block holds four words (front register, two
// queue entries, output register) before it stalls the input.
// The own boot id register must be written on the config channel only while
// no word is in flight; the block itself does not enforce this.
module boot_id_peer_tracker_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bipt_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bipt_pkg::out_word_t out_word_o
);
  import bipt_pkg::*;

  logic cmd_valid, cmd_full, q_not_empty, q_pop;
  cmd_t cmd, q_head;

  bipt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_full_i  (cmd_full)
  );

  bipt_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_valid),
    .push_data_i (cmd),
    .full_o      (cmd_full),
    .pop_i       (q_pop),
    .not_empty_o (q_not_empty),
    .head_o      (q_head)
  );

  bipt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_not_empty),
    .cmd_i       (q_head),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // No header: all header fields read zero
  a_no_send_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.send_valid) |->
      (out_word_o.out_req_tag == '0 && out_word_o.out_rpl_tag == '0 &&
       out_word_o.out_dst_boot_id == '0 && !out_word_o.out_query_flag))
    else $error("header fields set without send");

  // Release only on confirmation into NORMAL
  a_release_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.release_waiters) |->
      (out_word_o.state_now == ST_NORMAL &&
       out_word_o.timer_action == TMR_CANCEL))
    else $error("release without confirmation");

  // A query goes out only while a query is open
  a_query_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.out_query_flag) |->
      (out_word_o.state_now == ST_OPEN || out_word_o.state_now == ST_QUERY))
    else $error("query flag outside OPEN or QUERY");

  // Timer start always enters QUERY
  a_timer_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.timer_action == TMR_START) |->
      (out_word_o.state_now == ST_QUERY))
    else $error("timer start outside QUERY");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import bipt_pkg::*;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam int unsigned BATCH_LEN = 143;
  localparam int unsigned LONG_HOLD = 80;

  // Directed row: stimulus word, and a hand-written result where one is given
  typedef struct packed {
    in_word_t  w;
    logic      typed;
    out_word_t want;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [31:0] cfg_data_i;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  // Tracker state as predicted
  state_e      trk_state;
  logic [31:0] trk_peer;
  logic [31:0] trk_tag;
  logic [31:0] own_id;

  out_word_t   pending_q[$];
  dir_row_t    dir_tab[$];
  logic [31:0] id_pool[4];
  int unsigned hold_cycles;
  int unsigned n_words;
  int unsigned n_got;
  int unsigned n_mismatch;
  int unsigned n_settings;
  out_word_t   head;

  boot_id_peer_tracker_fsm u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Next-state and result of the tracker for one accepted word
  function automatic out_word_t track_peer(input in_word_t w);
    query_e    q;
    notify_e   note;
    timer_e    tmr;
    logic      send_msg;
    logic      reply;
    logic      rel;
    logic      send;
    out_word_t r;
    q = Q_NONE;
    note = NOTE_NONE;
    tmr = TMR_NONE;
    send_msg = 1'b0;
    reply = 1'b0;
    rel = 1'b0;
    r = '0;
    case (w.req_type)
      REQ_STATE: begin
        if (trk_state == ST_INIT) begin
          q = Q_NEW;
          trk_state = ST_OPEN;
        end
      end
      REQ_START_QUERY: begin
        if (trk_state == ST_NORMAL) begin
          trk_state = ST_QUERY;
          tmr = TMR_START;
          if (w.send_initial) q = Q_NEW;
        end
      end
      REQ_HEADER: begin
        // broadcast from the known peer is dropped whole
        if (!(w.flag_bcast && w.src_boot_id == trk_peer)) begin
          case (trk_state)
            ST_INIT: begin
              q = Q_NEW;
              trk_state = ST_OPEN;
            end
            ST_NORMAL: begin
              if (w.dst_boot_id != own_id && !w.flag_query) send_msg = 1'b1;
              if (w.src_boot_id != trk_peer) begin
                trk_state = ST_QUERY;
                tmr = TMR_START;
                q = Q_NEW;
              end
            end
            ST_OPEN: begin
              if (w.flag_bcast) begin
                q = Q_REPEAT;
              end else if (w.flag_response && w.in_rpl_tag == trk_tag) begin
                trk_peer = w.src_boot_id;
                tmr = TMR_CANCEL;
                rel = 1'b1;
                note = NOTE_FIRST;
                trk_state = ST_NORMAL;
              end
            end
            default: begin
              if (w.flag_bcast) begin
                q = Q_NEW;
              end else if (w.flag_response && w.in_rpl_tag == trk_tag) begin
                tmr = TMR_CANCEL;
                if (w.src_boot_id != trk_peer) begin
                  trk_peer = w.src_boot_id;
                  note = NOTE_REBOOTED;
                end
                trk_state = ST_NORMAL;
                rel = 1'b1;
              end
            end
          endcase
          reply = w.flag_query;
        end
      end
      default: ;
    endcase

    send = send_msg || q != Q_NONE || reply;
    if (send) begin
      // outstanding query rides along on anything sent while unconfirmed
      if (q == Q_NONE && (trk_state == ST_QUERY || trk_state == ST_OPEN)) q = Q_REPEAT;
      if (q == Q_NEW) trk_tag = w.new_tag;
      r.send_valid = 1'b1;
      r.out_query_flag = (q != Q_NONE);
      r.out_response_flag = reply;
      r.out_dst_boot_id = trk_peer;
      if (q != Q_NONE) r.out_req_tag = trk_tag;
      if (reply) r.out_rpl_tag = w.in_req_tag;
    end
    r.notify_code = note;
    r.release_waiters = rel;
    r.timer_action = tmr;
    r.state_now = trk_state;
    return r;
  endfunction

  function automatic in_word_t hdr_word(input logic bc, input logic qf, input logic rf,
                                        input logic [31:0] src, input logic [31:0] dst,
                                        input logic [31:0] ireq, input logic [31:0] irpl,
                                        input logic [31:0] ntag);
    in_word_t w;
    w.req_type = REQ_HEADER;
    w.flag_bcast = bc;
    w.flag_query = qf;
    w.flag_response = rf;
    w.src_boot_id = src;
    w.dst_boot_id = dst;
    w.in_req_tag = ireq;
    w.in_rpl_tag = irpl;
    w.new_tag = ntag;
    w.send_initial = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Non-header word; header fields carry junk the block must ignore
  function automatic in_word_t evt_word(input req_type_e t, input logic [31:0] ntag,
                                        input logic init);
    in_word_t w;
    w = hdr_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom, ntag);
    w.req_type = t;
    w.send_initial = init;
    return w;
  endfunction

  function automatic out_word_t res_word(input logic snd, input logic qf, input logic rf,
                                         input logic [31:0] dst, input logic [31:0] req,
                                         input logic [31:0] rpl, input notify_e n,
                                         input logic rel, input timer_e t, input state_e s);
    out_word_t r;
    r.send_valid = snd;
    r.out_query_flag = qf;
    r.out_response_flag = rf;
    r.out_dst_boot_id = dst;
    r.out_req_tag = req;
    r.out_rpl_tag = rpl;
    r.notify_code = n;
    r.release_waiters = rel;
    r.timer_action = t;
    r.state_now = s;
    return r;
  endfunction

  // Mostly well-formed traffic aimed at the current peer id and tag
  function automatic in_word_t rand_word();
    in_word_t    w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    w = evt_word(REQ_HEADER, $urandom, 1'($urandom_range(0, 1)));
    if (pick < 10) begin
      w.req_type = 2'($urandom_range(0, 3));
    end else if (pick < 25) begin
      w.req_type = REQ_START_QUERY;
    end else if (pick < 30) begin
      w.req_type = REQ_STATE;
    end else begin
      w.flag_bcast = ($urandom_range(0, 4) == 0);
      w.flag_query = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0, 1: w.src_boot_id = trk_peer;
        2: w.src_boot_id = id_pool[2'($urandom_range(0, 3))];
        default: ;
      endcase
      if ($urandom_range(0, 1)) w.dst_boot_id = own_id;
      if ($urandom_range(0, 4) < 3) w.in_rpl_tag = trk_tag;
    end
    return w;
  endfunction

  // Idle count per word, with quiet stretches of back-to-back traffic
  function automatic int unsigned draw_gap(input int unsigned idx);
    return (idx % 64 < 20) ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
    out_word_t pred;
    int unsigned gap;
    gap = draw_gap(n_words);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    pred = track_peer(w);
    pending_q.push_back(typed ? want : pred);
    n_words++;
  endtask

  // Stop offering and let every pending result come out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_own_id(input logic [31:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    own_id = v;
    n_settings++;
  endtask

  task automatic run_batch(input int unsigned len, input logic mid_pause);
    for (int unsigned i = 0; i < len; i++) begin
      if (mid_pause && i == len / 2) drain();
      send_word(rand_word(), 1'b0, '0);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("result %0d field %s: expected %h, got %h", n_got, name, want_v, got_v);
    end
  endtask

  // Receiver: random hold-off before each word, one long hold on request
  initial begin
    int unsigned n;
    int unsigned taken;
    taken = 0;
    out_stall_i <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_cycles != 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = draw_gap(taken + 30);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("result %0d arrived with none pending: %h", n_got,
                                       out_word_o);
      end else begin
        head = pending_q.pop_front();
        check_field("send_valid", 32'(head.send_valid), 32'(out_word_o.send_valid));
        check_field("out_query_flag", 32'(head.out_query_flag),
                    32'(out_word_o.out_query_flag));
        check_field("out_response_flag", 32'(head.out_response_flag),
                    32'(out_word_o.out_response_flag));
        check_field("out_dst_boot_id", head.out_dst_boot_id, out_word_o.out_dst_boot_id);
        check_field("out_req_tag", head.out_req_tag, out_word_o.out_req_tag);
        check_field("out_rpl_tag", head.out_rpl_tag, out_word_o.out_rpl_tag);
        check_field("notify_code", 32'(head.notify_code), 32'(out_word_o.notify_code));
        check_field("release_waiters", 32'(head.release_waiters),
                    32'(out_word_o.release_waiters));
        check_field("timer_action", 32'(head.timer_action), 32'(out_word_o.timer_action));
        check_field("state_now", 32'(head.state_now), 32'(out_word_o.state_now));
      end
      n_got++;
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Main sequence
  initial begin
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    in_word_i <= '0;
    trk_state = ST_INIT;
    trk_peer = '0;
    trk_tag = '0;
    own_id = '0;
    hold_cycles = 0;
    n_words = 0;
    n_got = 0;
    n_mismatch = 0;
    n_settings = 0;
    id_pool[0] = '0;
    id_pool[1] = ALL_ONES;
    id_pool[2] = $urandom;
    id_pool[3] = $urandom;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk from reset, own id still at its reset value of zero
    dir_tab.push_back('{evt_word(REQ_UNUSED, $urandom, 1'b1), 1'b1,
                        res_word(0, 0, 0, 0, 0, 0, NOTE_NONE, 0, TMR_NONE, ST_INIT)});
    dir_tab.push_back('{evt_word(REQ_START_QUERY, $urandom, 1'b1), 1'b1,
                        res_word(0, 0, 0, 0, 0, 0, NOTE_NONE, 0, TMR_NONE, ST_INIT)});
    dir_tab.push_back('{hdr_word(1, 1, 1, 0, ALL_ONES, ALL_ONES, 0, ALL_ONES), 1'b1,
                        res_word(0, 0, 0, 0, 0, 0, NOTE_NONE, 0, TMR_NONE, ST_INIT)});
    dir_tab.push_back('{evt_word(REQ_STATE, ALL_ONES, 1'b0), 1'b1,
                        res_word(1, 1, 0, 0, ALL_ONES, 0, NOTE_NONE, 0, TMR_NONE, ST_OPEN)});
    dir_tab.push_back('{evt_word(REQ_STATE, 0, 1'b0), 1'b1,
                        res_word(0, 0, 0, 0, 0, 0, NOTE_NONE, 0, TMR_NONE, ST_OPEN)});
    // broadcast from a stranger repeats the query, plus a reply
    dir_tab.push_back('{hdr_word(1, 1, 0, 5, 0, ALL_ONES, 0, 0), 1'b0, '0});
    // response with a stale tag
    dir_tab.push_back('{hdr_word(0, 0, 1, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_tab.push_back('{hdr_word(0, 0, 1, ALL_ONES, ALL_ONES, 0, ALL_ONES, 0), 1'b1,
                        res_word(0, 0, 0, 0, 0, 0, NOTE_FIRST, 1, TMR_CANCEL, ST_NORMAL)});
    dir_tab.push_back('{hdr_word(0, 0, 0, ALL_ONES, 0, 0, 0, 0), 1'b0, '0});
    // wrong destination id from the known peer
    dir_tab.push_back('{hdr_word(0, 0, 0, ALL_ONES, ALL_ONES, 0, 0, 0), 1'b0, '0});
    dir_tab.push_back('{hdr_word(0, 1, 0, ALL_ONES, 0, 32'h1234_5678, 0, 0), 1'b0, '0});
    dir_tab.push_back('{evt_word(REQ_START_QUERY, 32'h0BAD_F00D, 1'b0), 1'b0, '0});
    dir_tab.push_back('{evt_word(REQ_START_QUERY, 32'h1111_2222, 1'b1), 1'b0, '0});
    // reply in QUERY carries the outstanding tag along
    dir_tab.push_back('{hdr_word(0, 1, 0, ALL_ONES, 0, 32'h8000_0001, 0, 0), 1'b0, '0});
    dir_tab.push_back('{hdr_word(1, 1, 1, ALL_ONES, 0, 0, ALL_ONES, 0), 1'b0, '0});
    dir_tab.push_back('{hdr_word(1, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    // matching response from a new id: peer rebooted
    dir_tab.push_back('{hdr_word(0, 0, 1, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_tab.push_back('{evt_word(REQ_START_QUERY, 32'hA5A5_A5A5, 1'b1), 1'b0, '0});
    dir_tab.push_back('{hdr_word(0, 0, 1, 0, 0, 0, 32'hA5A5_A5A5, 0), 1'b0, '0});
    dir_tab.push_back('{hdr_word(0, 1, 0, 32'h7FFF_FFFF, ALL_ONES, 32'h5A5A_5A5A, 0,
                                 32'hC3C3_C3C3), 1'b0, '0});
    dir_tab.push_back('{hdr_word(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_tab.push_back('{evt_word(REQ_STATE, 0, 1'b0), 1'b0, '0});
    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].want);
    drain();

    // Random phases under different own ids; first one starts under a long hold
    write_own_id(ALL_ONES);
    hold_cycles = LONG_HOLD;
    run_batch(BATCH_LEN, 1'b0);
    drain();
    write_own_id($urandom);
    run_batch(BATCH_LEN, 1'b1);
    drain();
    write_own_id('0);
    run_batch(BATCH_LEN, 1'b0);
    drain();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d words (directed walk plus random traffic), checked %0d results.",
             n_words, n_got);
    $display("Own id took %0d settings incl. both extremes; one %0d-cycle output hold.",
             n_settings, LONG_HOLD);
    if (n_mismatch == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/bipt_pkg.sv
rtl/core/bipt_front.sv
rtl/core/bipt_cmd_fifo.sv
rtl/core/bipt_back.sv
rtl/core/boot_id_peer_tracker_fsm.sv
tb/tb.sv
